/* hdl/assert_macros.svh */
// Assertion macros used by the result-channel checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/tle_pkg.sv */
// Shared types, codes and constants of the terminal line editor.
package tle_pkg;

    // Field widths
    localparam int CHAR_W      = 7;
    localparam int CUR_W       = 6;
    localparam int CNT_W       = 6;
    localparam int ACT_W       = 3;
    localparam int BYTE_W      = 8;

    // Default line length and command queue depth
    localparam int DEF_LINE_LEN = 40;
    localparam int QUEUE_DEPTH  = 2;

    // Key codes
    localparam logic [BYTE_W-1:0] KEY_EOF    = 8'd4;
    localparam logic [BYTE_W-1:0] KEY_KILL   = 8'd21;
    localparam logic [BYTE_W-1:0] KEY_WERASE = 8'd23;
    localparam logic [BYTE_W-1:0] KEY_ESC    = 8'd27;
    localparam logic [BYTE_W-1:0] KEY_DEL    = 8'd127;
    localparam logic [BYTE_W-1:0] PRINT_LO   = 8'd32;
    localparam logic [BYTE_W-1:0] PRINT_HI   = 8'd126;
    localparam logic [BYTE_W-1:0] CH_LBRACK  = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_UP      = 8'h41;
    localparam logic [BYTE_W-1:0] CH_DOWN    = 8'h42;
    localparam logic [BYTE_W-1:0] CH_RIGHT   = 8'h43;
    localparam logic [BYTE_W-1:0] CH_LEFT    = 8'h44;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 7'h20;

    // Result actions
    typedef enum logic [ACT_W-1:0] {
        ACT_ECHO    = 3'd0,
        ACT_ERASE   = 3'd1,
        ACT_LEFT    = 3'd2,
        ACT_RIGHT   = 3'd3,
        ACT_BELL    = 3'd4,
        ACT_NEWLINE = 3'd5,
        ACT_END     = 3'd6
    } t_action;

    // Commands passed from the front end to the executor
    typedef enum logic [2:0] {
        CMD_PRINT,
        CMD_BELL,
        CMD_ERASE,
        CMD_KILL,
        CMD_WERASE,
        CMD_EOF,
        CMD_LEFT,
        CMD_RIGHT
    } t_cmd;

    typedef struct packed {
        t_cmd              cmd;
        logic [CHAR_W-1:0] ch;
    } t_cmd_item;

    // Queue write side
    typedef struct packed {
        logic      push;
        t_cmd_item item;
    } t_q_wr;

    // Queue read side
    typedef struct packed {
        logic      valid;
        t_cmd_item item;
    } t_q_rd;

    // Escape sequence tracking
    typedef enum logic [1:0] {
        ESC_NONE,
        ESC_SEEN,
        ESC_BRACKET,
        ESC_SKIP
    } t_esc;

    // Executor states
    typedef enum logic [2:0] {
        BS_IDLE,
        BS_DISPATCH,
        BS_SCAN,
        BS_WREAD,
        BS_WCHECK,
        BS_EMIT
    } t_bstate;

endpackage

/* hdl/tle_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/tle_front.sv */
// Front end: accepts key bytes, tracks escape sequences, classifies into commands.
module tle_front
    import tle_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [BYTE_W-1:0] i_in_byte,
    output logic              o_ready,
    input  logic              i_full,
    output t_q_wr             o_wr
);

    t_esc r_esc;
    t_esc n_esc;
    logic w_acc;

    assign o_ready = !i_full;
    assign w_acc   = i_valid && !i_full;

    // Escape phase next state
    always_comb begin
        n_esc = r_esc;
        if (w_acc) begin
            unique case (r_esc)
                ESC_NONE:    n_esc = (i_in_byte == KEY_ESC) ? ESC_SEEN : ESC_NONE;
                ESC_SEEN:    n_esc = (i_in_byte == CH_LBRACK) ? ESC_BRACKET : ESC_SKIP;
                ESC_BRACKET: n_esc = ESC_NONE;
                ESC_SKIP:    n_esc = ESC_NONE;
                default:     n_esc = ESC_NONE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc <= ESC_NONE;
        end else begin
            r_esc <= n_esc;
        end
    end

    // Byte classification
    always_comb begin
        o_wr.item.ch  = i_in_byte[CHAR_W-1:0];
        o_wr.item.cmd = CMD_BELL;
        o_wr.push     = 1'b0;
        unique case (r_esc)
            ESC_NONE: begin
                o_wr.push = w_acc && (i_in_byte != KEY_ESC);
                priority if (i_in_byte == KEY_EOF) begin
                    o_wr.item.cmd = CMD_EOF;
                end else if (i_in_byte == KEY_DEL) begin
                    o_wr.item.cmd = CMD_ERASE;
                end else if (i_in_byte == KEY_KILL) begin
                    o_wr.item.cmd = CMD_KILL;
                end else if (i_in_byte == KEY_WERASE) begin
                    o_wr.item.cmd = CMD_WERASE;
                end else if (i_in_byte >= PRINT_LO && i_in_byte <= PRINT_HI) begin
                    o_wr.item.cmd = CMD_PRINT;
                end else begin
                    o_wr.item.cmd = CMD_BELL;
                end
            end
            ESC_BRACKET: begin
                if (i_in_byte == CH_UP || i_in_byte == CH_LEFT) begin
                    o_wr.item.cmd = CMD_LEFT;
                    o_wr.push     = w_acc;
                end else if (i_in_byte == CH_DOWN || i_in_byte == CH_RIGHT) begin
                    o_wr.item.cmd = CMD_RIGHT;
                    o_wr.push     = w_acc;
                end
            end
            ESC_SEEN, ESC_SKIP: begin
                o_wr.push = 1'b0;
            end
            default: begin
                o_wr.push = 1'b0;
            end
        endcase
    end

endmodule

/* hdl/tle_fifo.sv */
// Short command queue between the front end and the executor.
module tle_fifo
    import tle_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_q_wr i_wr,
    output logic  o_full,
    output t_q_rd o_rd,
    input  logic  i_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

    t_cmd_item         r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_head;
    logic [PTR_W-1:0]  r_tail;
    logic [CNT_QW-1:0] r_count;
    logic              w_push;
    logic              w_pop;

    assign o_full     = (r_count == CNT_QW'(QUEUE_DEPTH));
    assign o_rd.valid = (r_count != '0);
    assign o_rd.item  = r_mem[r_head];
    assign w_push     = i_wr.push && !o_full;
    assign w_pop      = i_pop && o_rd.valid;

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_tail] <= i_wr.item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_tail <= (r_tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_tail + PTR_W'(1);
            end
            if (w_pop) begin
                r_head <= (r_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CNT_QW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CNT_QW'(1);
            end
        end
    end

endmodule

/* hdl/tle_back.sv */
// Executor: applies commands to the line store and cursor, drives result items.
module tle_back
    import tle_pkg::*;
#(
    parameter int LINE_LEN = DEF_LINE_LEN
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_q_rd             i_q,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [ACT_W-1:0]  o_action,
    output logic [CHAR_W-1:0] o_echo_char,
    output logic [CNT_W-1:0]  o_erase_count,
    output logic              o_last
);

    localparam int IDX_W = $clog2(LINE_LEN);

    t_bstate r_state, n_state;

    logic [CUR_W-1:0]    r_cursor, n_cursor;
    logic                r_halted, n_halted;
    logic [LINE_LEN-1:0] r_full, n_full;     // entry holds a character
    t_cmd                r_cmd, n_cmd;
    logic [CHAR_W-1:0]   r_ch, n_ch;
    logic [CUR_W-1:0]    r_idx, n_idx;
    logic                r_word, n_word;

    // Pending result
    t_action             r_p_act, n_p_act;
    logic [CHAR_W-1:0]   r_p_ch, n_p_ch;
    logic [CNT_W-1:0]    r_p_cnt, n_p_cnt;
    logic                r_p_last, n_p_last;
    logic                r_nl, n_nl;

    // Output register
    logic                r_o_valid, n_o_valid;
    t_action             r_o_act, n_o_act;
    logic [CHAR_W-1:0]   r_o_ch, n_o_ch;
    logic [CNT_W-1:0]    r_o_cnt, n_o_cnt;
    logic                r_o_last, n_o_last;

    logic [CUR_W-1:0]    w_cur_m1;
    logic                w_out_free;
    logic                w_space;
    logic                w_we;
    logic [CHAR_W-1:0]   w_rdata;

    assign w_cur_m1   = r_cursor - CUR_W'(1);
    assign w_out_free = !r_o_valid || i_ready;
    assign w_space    = r_full[w_cur_m1[IDX_W-1:0]] && (w_rdata == CH_SPACE);

    // Line store characters; emptiness lives in r_full
    tle_ram #(
        .WIDTH(CHAR_W),
        .DEPTH(LINE_LEN)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_cursor[IDX_W-1:0]),
        .i_wdata(r_ch),
        .i_raddr(w_cur_m1[IDX_W-1:0]),
        .o_rdata(w_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_IDLE: begin
                if (i_q.valid && !r_halted) begin
                    n_state = BS_DISPATCH;
                end
            end
            BS_DISPATCH: begin
                unique case (r_cmd)
                    CMD_PRINT, CMD_BELL, CMD_ERASE: n_state = BS_EMIT;
                    CMD_KILL:   n_state = (r_cursor != '0) ? BS_EMIT : BS_IDLE;
                    CMD_EOF:    n_state = (r_cursor == '0) ? BS_EMIT : BS_IDLE;
                    CMD_LEFT:   n_state = (r_cursor != '0) ? BS_EMIT : BS_IDLE;
                    // Cursor past the last entry has nowhere to go
                    CMD_RIGHT:  n_state = (r_cursor < CUR_W'(LINE_LEN)) ? BS_SCAN : BS_IDLE;
                    CMD_WERASE: n_state = BS_WREAD;
                    default:    n_state = BS_IDLE;
                endcase
            end
            BS_SCAN: begin
                priority if (!r_full[r_idx[IDX_W-1:0]]) begin
                    n_state = BS_IDLE;
                end else if (r_idx == r_cursor) begin
                    n_state = BS_EMIT;
                end else begin
                    n_state = BS_SCAN;
                end
            end
            BS_WREAD: begin
                if (r_cursor == '0) begin
                    n_state = (r_p_cnt != '0) ? BS_EMIT : BS_IDLE;
                end else begin
                    n_state = BS_WCHECK;
                end
            end
            BS_WCHECK: begin
                if (r_word && w_space) begin
                    n_state = (r_p_cnt != '0) ? BS_EMIT : BS_IDLE;
                end else begin
                    n_state = BS_WREAD;
                end
            end
            BS_EMIT: begin
                if (w_out_free && !r_nl) begin
                    n_state = BS_IDLE;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        n_cursor  = r_cursor;
        n_halted  = r_halted;
        n_full    = r_full;
        n_cmd     = r_cmd;
        n_ch      = r_ch;
        n_idx     = r_idx;
        n_word    = r_word;
        n_p_act   = r_p_act;
        n_p_ch    = r_p_ch;
        n_p_cnt   = r_p_cnt;
        n_p_last  = r_p_last;
        n_nl      = r_nl;
        n_o_act   = r_o_act;
        n_o_ch    = r_o_ch;
        n_o_cnt   = r_o_cnt;
        n_o_last  = r_o_last;
        n_o_valid = i_ready ? 1'b0 : r_o_valid;
        o_pop     = 1'b0;
        w_we      = 1'b0;

        unique case (r_state)
            BS_IDLE: begin
                // Commands after a halt are dropped
                o_pop = i_q.valid;
                n_cmd = i_q.item.cmd;
                n_ch  = i_q.item.ch;
            end
            BS_DISPATCH: begin
                n_p_ch   = '0;
                n_p_cnt  = '0;
                n_p_last = 1'b1;
                n_nl     = 1'b0;
                n_p_act  = ACT_BELL;
                unique case (r_cmd)
                    CMD_PRINT: begin
                        if (r_cursor < CUR_W'(LINE_LEN)) begin
                            w_we = 1'b1;
                            n_full[r_cursor[IDX_W-1:0]] = 1'b1;
                            n_p_act = ACT_ECHO;
                            n_p_ch  = r_ch;
                            // Line full: newline follows, cursor wraps
                            if (r_cursor == CUR_W'(LINE_LEN - 1)) begin
                                n_cursor = '0;
                                n_p_last = 1'b0;
                                n_nl     = 1'b1;
                            end else begin
                                n_cursor = r_cursor + CUR_W'(1);
                            end
                        end
                    end
                    CMD_BELL: begin
                        n_p_act = ACT_BELL;
                    end
                    CMD_ERASE: begin
                        if (r_cursor != '0) begin
                            n_cursor = w_cur_m1;
                            n_full[w_cur_m1[IDX_W-1:0]] = 1'b0;
                            n_p_act = ACT_ERASE;
                            n_p_cnt = CNT_W'(1);
                        end
                    end
                    CMD_KILL: begin
                        n_full[0] = 1'b0;
                        n_cursor  = '0;
                        n_p_act   = ACT_ERASE;
                        n_p_cnt   = CNT_W'(r_cursor);
                    end
                    CMD_EOF: begin
                        n_p_act = ACT_END;
                        if (r_cursor == '0) begin
                            n_halted = 1'b1;
                        end
                    end
                    CMD_LEFT: begin
                        n_p_act = ACT_LEFT;
                        if (r_cursor != '0) begin
                            n_cursor = w_cur_m1;
                        end
                    end
                    CMD_RIGHT: begin
                        n_p_act = ACT_RIGHT;
                        n_idx   = '0;
                    end
                    CMD_WERASE: begin
                        n_p_act = ACT_ERASE;
                        n_word  = 1'b0;
                    end
                    default: begin
                        n_p_act = ACT_BELL;
                    end
                endcase
            end
            BS_SCAN: begin
                // Right move allowed only if every entry up to the cursor is filled
                if (r_full[r_idx[IDX_W-1:0]]) begin
                    if (r_idx == r_cursor) begin
                        n_cursor = r_cursor + CUR_W'(1);
                    end else begin
                        n_idx = r_idx + CUR_W'(1);
                    end
                end
            end
            BS_WREAD: begin
                // Read address is the entry before the cursor
            end
            BS_WCHECK: begin
                // Spaces first, then the word before them
                if (!(r_word && w_space)) begin
                    n_cursor = w_cur_m1;
                    n_full[w_cur_m1[IDX_W-1:0]] = 1'b0;
                    n_p_cnt = r_p_cnt + CNT_W'(1);
                    if (!w_space) begin
                        n_word = 1'b1;
                    end
                end
            end
            BS_EMIT: begin
                if (w_out_free) begin
                    n_o_valid = 1'b1;
                    n_o_act   = r_p_act;
                    n_o_ch    = r_p_ch;
                    n_o_cnt   = r_p_cnt;
                    n_o_last  = r_p_last;
                    if (r_nl) begin
                        n_p_act  = ACT_NEWLINE;
                        n_p_ch   = '0;
                        n_p_cnt  = '0;
                        n_p_last = 1'b1;
                        n_nl     = 1'b0;
                    end
                end
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BS_IDLE;
            r_cursor  <= '0;
            r_halted  <= 1'b0;
            r_full    <= '0;
            r_nl      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cursor  <= n_cursor;
            r_halted  <= n_halted;
            r_full    <= n_full;
            r_nl      <= n_nl;
            r_o_valid <= n_o_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_ch     <= n_ch;
        r_idx    <= n_idx;
        r_word   <= n_word;
        r_p_act  <= n_p_act;
        r_p_ch   <= n_p_ch;
        r_p_cnt  <= n_p_cnt;
        r_p_last <= n_p_last;
        r_o_act  <= n_o_act;
        r_o_ch   <= n_o_ch;
        r_o_cnt  <= n_o_cnt;
        r_o_last <= n_o_last;
    end

    assign o_valid       = r_o_valid;
    assign o_action      = r_o_act;
    assign o_echo_char   = r_o_ch;
    assign o_erase_count = r_o_cnt;
    assign o_last        = r_o_last;

endmodule

/* hdl/terminal_line_editor.sv */
// Terminal line editor: byte intake, escape handling, command queue, line editing core.
// A taken byte goes through the queue and the executor's idle, dispatch and emit states
// to the output register. Bytes are taken one per cycle into a 2-entry queue while it is
//   not full; the executor takes one command at a time, adds a newline item on a wrap,
//   walks filled entries on a right move, and reads then checks each word-erase entry.
// Reset (synchronous, active low) empties the line, cursor 0, clears escape and halt.
module terminal_line_editor
    import tle_pkg::*;
#(
    parameter int LINE_LEN = DEF_LINE_LEN
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [BYTE_W-1:0] i_in_byte,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [ACT_W-1:0]  o_action,
    output logic [CHAR_W-1:0] o_echo_char,
    output logic [CNT_W-1:0]  o_erase_count,
    output logic              o_last
);

    t_q_wr w_wr;
    t_q_rd w_rd;
    logic  w_full;
    logic  w_pop;

    // Intake and classification
    tle_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_in_byte(i_in_byte),
        .o_ready  (o_ready),
        .i_full   (w_full),
        .o_wr     (w_wr)
    );

    // Command queue
    tle_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (w_wr),
        .o_full (w_full),
        .o_rd   (w_rd),
        .i_pop  (w_pop)
    );

    // Editing core
    tle_back #(
        .LINE_LEN(LINE_LEN)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q          (w_rd),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_action     (o_action),
        .o_echo_char  (o_echo_char),
        .o_erase_count(o_erase_count),
        .o_last       (o_last)
    );

endmodule

/* hdl/tle_checker.sv */
// Port-level checks on the result channel of the terminal line editor.
`include "assert_macros.svh"

module tle_checker
    import tle_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic              i_ready,
    input logic [ACT_W-1:0]  o_action,
    input logic [CHAR_W-1:0] o_echo_char,
    input logic [CNT_W-1:0]  o_erase_count,
    input logic              o_last
);

    // Stalled result holds
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_action) && $stable(o_echo_char) && $stable(o_erase_count) && $stable(o_last), "stalled item changed")

    // Echo character only on echo
    `ASSERT_NOW(a_char_zero, i_clk, i_rst_n, o_valid && (o_action != ACT_ECHO), o_echo_char == '0, "echo_char set on non-echo item")

    // Erase count only on erase, and never zero there
    `ASSERT_NOW(a_cnt, i_clk, i_rst_n, o_valid, (o_action == ACT_ERASE) == (o_erase_count != '0), "erase_count mismatch")

    // Only an echo that wraps the line can be followed by another item
    `ASSERT_NOW(a_not_last, i_clk, i_rst_n, o_valid && !o_last, o_action == ACT_ECHO, "non-final item is not an echo")

endmodule

bind terminal_line_editor tle_checker u_tle_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_action     (o_action),
    .o_echo_char  (o_echo_char),
    .o_erase_count(o_erase_count),
    .o_last       (o_last)
);

/* tb/sv/tle_echo_checker.sv */
// Echo-action checker for the terminal line editor: predicts and compares result items.
module tle_echo_checker
    import tle_pkg::*;
#(
    parameter int LINE_LEN = DEF_LINE_LEN
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_key_valid,
    input  logic              i_key_ready,
    input  logic [BYTE_W-1:0] i_key,
    input  logic              i_act_valid,
    input  logic              i_act_ready,
    input  logic [ACT_W-1:0]  i_action,
    input  logic [CHAR_W-1:0] i_echo_char,
    input  logic [CNT_W-1:0]  i_erase_count,
    input  logic              i_last,
    output int                o_errors,
    output int                o_pending,
    output int                o_checked,
    output logic              o_at_home
);

    typedef struct packed {
        t_action           act;
        logic [CHAR_W-1:0] ch;
        logic [CNT_W-1:0]  cnt;
        logic              fin;
    } t_echo;

    // Shadow of the editor state
    logic [CHAR_W-1:0] line_buf [LINE_LEN];
    int                col;
    t_esc              esc;
    bit                stopped;

    t_echo echo_due [$];
    int    errors  = 0;
    int    checked = 0;

    assign o_errors  = errors;
    assign o_pending = echo_due.size();
    assign o_checked = checked;
    // Ctrl-D would end input if it were the next item
    assign o_at_home = !stopped && (esc == ESC_NONE) && (col == 0);

    task automatic report(input string what, input int got, input int want);
        $display("checker: %s mismatch, got %0d expected %0d (item %0d)", what, got, want,
                 checked);
        errors++;
    endtask

    task automatic push_echo(input t_action a, input logic [CHAR_W-1:0] c,
                             input logic [CNT_W-1:0] n, input logic f);
        t_echo e;
        e.act = a;
        e.ch  = c;
        e.cnt = n;
        e.fin = f;
        echo_due.push_back(e);
    endtask

    function automatic int first_empty();
        for (int i = 0; i < LINE_LEN; i++)
            if (line_buf[i] == '0)
                return i;
        return LINE_LEN;
    endfunction

    // Apply one key to the shadow line and queue the actions it echoes
    task automatic edit_key(input logic [BYTE_W-1:0] k);
        int                n;
        logic [CHAR_W-1:0] ch;
        ch = k[CHAR_W-1:0];
        n  = 0;
        if (stopped)
            return;
        // escape sequence in progress
        if (esc == ESC_SEEN) begin
            esc = (k == CH_LBRACK) ? ESC_BRACKET : ESC_SKIP;
            return;
        end
        if (esc == ESC_SKIP) begin
            esc = ESC_NONE;
            return;
        end
        if (esc == ESC_BRACKET) begin
            esc = ESC_NONE;
            if (k == CH_UP || k == CH_LEFT) begin
                if (col > 0) begin
                    col--;
                    push_echo(ACT_LEFT, '0, '0, 1'b1);
                end
            end else if (k == CH_DOWN || k == CH_RIGHT) begin
                if (col < first_empty()) begin
                    col++;
                    push_echo(ACT_RIGHT, '0, '0, 1'b1);
                end
            end
            return;
        end
        case (k)
            KEY_ESC: esc = ESC_SEEN;
            KEY_EOF: begin
                if (col == 0) begin
                    stopped = 1'b1;
                    push_echo(ACT_END, '0, '0, 1'b1);
                end
            end
            KEY_DEL: begin
                if (col > 0) begin
                    col--;
                    line_buf[col] = '0;
                    push_echo(ACT_ERASE, '0, CNT_W'(1), 1'b1);
                end else begin
                    push_echo(ACT_BELL, '0, '0, 1'b1);
                end
            end
            KEY_KILL: begin
                // only the first entry is cleared
                n = col;
                col = 0;
                line_buf[0] = '0;
                if (n > 0)
                    push_echo(ACT_ERASE, '0, CNT_W'(n), 1'b1);
            end
            KEY_WERASE: begin
                // trailing spaces first, then the word before them
                while (col > 0 && line_buf[col-1] == CH_SPACE) begin
                    col--;
                    line_buf[col] = '0;
                    n++;
                end
                while (col > 0 && line_buf[col-1] != CH_SPACE) begin
                    col--;
                    line_buf[col] = '0;
                    n++;
                end
                if (n > 0)
                    push_echo(ACT_ERASE, '0, CNT_W'(n), 1'b1);
            end
            default: begin
                if (k >= PRINT_LO && k <= PRINT_HI && col < LINE_LEN) begin
                    line_buf[col] = ch;
                    col++;
                    if (col == LINE_LEN) begin
                        // line full: newline, cursor home, contents kept
                        col = 0;
                        push_echo(ACT_ECHO, ch, '0, 1'b0);
                        push_echo(ACT_NEWLINE, '0, '0, 1'b1);
                    end else begin
                        push_echo(ACT_ECHO, ch, '0, 1'b1);
                    end
                end else begin
                    push_echo(ACT_BELL, '0, '0, 1'b1);
                end
            end
        endcase
    endtask

    // Compare results first, then account for the key taken at this edge
    always @(posedge i_clk) begin
        t_echo e;
        if (!i_rst_n) begin
            foreach (line_buf[i])
                line_buf[i] = '0;
            col     = 0;
            esc     = ESC_NONE;
            stopped = 1'b0;
            echo_due.delete();
        end else begin
            if (i_act_valid && i_act_ready) begin
                if (echo_due.size() == 0) begin
                    report("unexpected result, action", int'(i_action), -1);
                end else begin
                    e = echo_due.pop_front();
                    if (i_action !== e.act)
                        report("action", int'(i_action), int'(e.act));
                    if (i_echo_char !== e.ch)
                        report("echo_char", int'(i_echo_char), int'(e.ch));
                    if (i_erase_count !== e.cnt)
                        report("erase_count", int'(i_erase_count), int'(e.cnt));
                    if (i_last !== e.fin)
                        report("last", int'(i_last), int'(e.fin));
                end
                checked++;
            end
            if (i_key_valid && i_key_ready)
                edit_key(i_key);
        end
    end

endmodule

/* tb/sv/testbench.sv */
// Top of the terminal line editor testbench: clock, reset, key stimulus and verdict.
module testbench;
    import tle_pkg::*;

    localparam int LINE_LEN   = DEF_LINE_LEN;
    localparam int KEY_ITEMS  = 1750;
    localparam int CALM_FROM  = 1500;
    localparam int IDLE_LIMIT = 4000;
    localparam int TAIL       = 200;

    logic              clk;
    logic              rst_n;
    logic              key_valid;
    logic [BYTE_W-1:0] key_byte;
    logic              key_ready;
    logic              act_valid;
    logic              act_ready = 1'b0;
    logic [ACT_W-1:0]  act;
    logic [CHAR_W-1:0] echo_ch;
    logic [CNT_W-1:0]  erase_n;
    logic              act_last;

    int   errors;
    int   pending;
    int   checked;
    logic at_home;

    bit   quiet      = 1'b0;
    int   sent       = 0;
    int   stall_left = 0;
    int   idle_run   = 0;

    terminal_line_editor #(
        .LINE_LEN(LINE_LEN)
    ) dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (key_valid),
        .i_in_byte     (key_byte),
        .o_ready       (key_ready),
        .o_valid       (act_valid),
        .i_ready       (act_ready),
        .o_action      (act),
        .o_echo_char   (echo_ch),
        .o_erase_count (erase_n),
        .o_last        (act_last)
    );

    tle_echo_checker #(
        .LINE_LEN(LINE_LEN)
    ) chk (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_key_valid   (key_valid),
        .i_key_ready   (key_ready),
        .i_key         (key_byte),
        .i_act_valid   (act_valid),
        .i_act_ready   (act_ready),
        .i_action      (act),
        .i_echo_char   (echo_ch),
        .i_erase_count (erase_n),
        .i_last        (act_last),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_at_home     (at_home)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Result side: random stall bursts, none while quiet
    always @(posedge clk) begin
        if (quiet || !rst_n) begin
            act_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            act_ready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 14);
            act_ready <= 1'b0;
        end else begin
            act_ready <= 1'b1;
        end
    end

    // Watchdog on cycles where neither channel moves an item
    always @(posedge clk) begin
        if (rst_n) begin
            if ((key_valid && key_ready) || (act_valid && act_ready)) begin
                idle_run = 0;
            end else begin
                idle_run++;
                if (idle_run >= IDLE_LIMIT) begin
                    $display("testbench: no progress for %0d cycles", IDLE_LIMIT);
                    $display("testbench: done, errors");
                    $finish;
                end
            end
        end
    end

    // Present one key and hold it until taken. A Ctrl-D is only let through at
    // column 0 when may_end is set; the check runs with key_valid dropped first, so the
    // shadow state already holds every earlier key.
    task automatic send_key(input logic [BYTE_W-1:0] k, input bit may_end);
        logic [BYTE_W-1:0] b;
        b = k;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            key_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        if (b == KEY_EOF) begin
            key_valid <= 1'b0;
            @(posedge clk);
            if (at_home && !may_end)
                b = KEY_DEL;
        end
        key_valid <= 1'b1;
        key_byte  <= b;
        do
            @(posedge clk);
        while (!key_ready);
        sent++;
    endtask

    // A word of printables, now and then long enough to wrap the line
    task automatic type_word();
        int                n;
        logic [BYTE_W-1:0] c;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 45) : $urandom_range(1, 8);
        repeat (n) begin
            c = ($urandom_range(0, 5) == 0) ? PRINT_LO : BYTE_W'($urandom_range(33, 126));
            send_key(c, 1'b0);
        end
        if ($urandom_range(0, 1) == 0)
            send_key(PRINT_LO, 1'b0);
    endtask

    task automatic send_arrow();
        logic [BYTE_W-1:0] dir;
        case ($urandom_range(0, 4))
            0: dir = CH_UP;
            1: dir = CH_DOWN;
            2: dir = CH_RIGHT;
            3: dir = CH_LEFT;
            default: dir = BYTE_W'($urandom_range(0, 255));
        endcase
        send_key(KEY_ESC, 1'b0);
        send_key(CH_LBRACK, 1'b0);
        send_key(dir, 1'b0);
    endtask

    initial begin
        logic [BYTE_W-1:0] warmup [0:25];
        int                pick;
        rst_n     = 1'b0;
        key_valid = 1'b0;
        key_byte  = '0;
        warmup = '{KEY_DEL, KEY_KILL, KEY_WERASE, KEY_ESC, CH_LBRACK, CH_UP,
                   PRINT_LO, PRINT_HI, "a", PRINT_LO, PRINT_LO, KEY_WERASE,
                   KEY_ESC, CH_LBRACK, CH_LEFT, KEY_ESC, CH_LBRACK, CH_RIGHT,
                   KEY_EOF, KEY_ESC, "x", "y", 8'd0, 8'd255, KEY_DEL, KEY_KILL};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: bell at column 0, empty kill/word erase, arrows at the left limit
        // and inside the line, word erase over trailing spaces, discarded escape, odd bytes
        foreach (warmup[i])
            send_key(warmup[i], 1'b0);

        // Random editing sessions
        while (sent < KEY_ITEMS) begin
            quiet = (sent >= CALM_FROM) || ((sent / 250) % 4 == 3);
            pick  = $urandom_range(0, 99);
            if (pick < 40)
                type_word();
            else if (pick < 55)
                send_arrow();
            else if (pick < 65)
                send_key(KEY_DEL, 1'b0);
            else if (pick < 69)
                send_key(KEY_KILL, 1'b0);
            else if (pick < 79)
                send_key(KEY_WERASE, 1'b0);
            else if (pick < 83 && !quiet)
                send_key(KEY_EOF, 1'b0);
            else if (pick < 88) begin
                send_key(KEY_ESC, 1'b0);
                send_key(BYTE_W'($urandom_range(0, 255)), 1'b0);
                send_key(BYTE_W'($urandom_range(0, 255)), 1'b0);
            end else
                send_key(BYTE_W'($urandom_range(0, 255)), 1'b0);
        end

        // Bring the line home, end input, then check that later keys are ignored
        quiet = 1'b1;
        forever begin
            key_valid <= 1'b0;
            @(posedge clk);
            if (at_home)
                break;
            send_key(KEY_KILL, 1'b0);
        end
        send_key(KEY_EOF, 1'b1);
        repeat (3) send_key(BYTE_W'($urandom_range(0, 255)), 1'b0);
        key_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (TAIL) @(posedge clk);

        $display("testbench: %0d keys sent (typing, arrows, erases, escapes, noise)", sent);
        $display("testbench: %0d echo actions checked, input ended by Ctrl-D", checked);
        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
